// File: sv/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg
// Types and constants shared by the reading change warning check modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rcw_pkg;

    // Datapath widths
    localparam int unsigned RD_W   = 16;   // meter reading
    localparam int unsigned TRD_W  = 14;   // trend register
    localparam int unsigned BRD_W  = 8;    // border repeat budget
    localparam int unsigned OUT_W  = 23;   // bound and ratio fields
    localparam int unsigned CODE_W = 3;    // warning code
    localparam int unsigned DIV_W  = 30;   // divider dividend and quotient
    localparam int unsigned DSR_W  = 16;   // divider divisor
    localparam int unsigned CFG_W  = 2;    // register index

    localparam int unsigned NUM_CODES = 6;

    // Register indexes
    localparam logic [CFG_W-1:0] REG_TOP_LIMIT = 2'd0;
    localparam logic [CFG_W-1:0] REG_TREND     = 2'd1;
    localparam logic [CFG_W-1:0] REG_BORDER    = 2'd2;

    // Warning codes
    localparam logic [CODE_W-1:0] CODE_OK     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ZERO   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_TOP    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_UP     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DOWN   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_REPEAT = 3'd5;

    localparam logic [TRD_W-1:0] PERCENT = 14'd100;
    localparam logic [OUT_W-1:0] SAT_MAX = 23'h7F_FFFF;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_HI,
        S_MUL_CUR,
        S_CMP_UP,
        S_MUL_LO,
        S_MUL_PRV,
        S_CMP_DN,
        S_DIV_BND,
        S_DIV_RAT,
        S_FINISH
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    // Saturate a quotient to the 23-bit result fields
    function automatic logic [OUT_W-1:0] sat23(input logic [DIV_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (|v[DIV_W-1:OUT_W]) begin
            r = SAT_MAX;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/rcw_in_if.sv
// ----------------------------------------------------------------------------
// rcw_in_if
// Input channel: one pair of meter readings and a check mode per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcw_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] previous_reading;
    logic [15:0] current_reading;

    modport source (output valid, mode, previous_reading, current_reading, input ready);
    modport sink   (input valid, mode, previous_reading, current_reading, output ready);
endinterface

`default_nettype wire

// File: sv/rcw_out_if.sv
// ----------------------------------------------------------------------------
// rcw_out_if
// Result channel: warning code, crossed bound, ratio and re-read request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcw_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  warning_code;
    logic [22:0] bound_value;
    logic [22:0] ratio_percent;
    logic [15:0] warning_count;
    logic        reread_request;
    logic [7:0]  repeat_budget;

    modport source (output valid, warning_code, bound_value, ratio_percent,
                    warning_count, reread_request, repeat_budget, input ready);
    modport sink   (input valid, warning_code, bound_value, ratio_percent,
                    warning_count, reread_request, repeat_budget, output ready);
endinterface

`default_nettype wire

// File: sv/rcw_div.sv
// ----------------------------------------------------------------------------
// rcw_div
// Restoring serial divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rcw_pkg::t_div_req i_req,
    output rcw_pkg::t_div_rsp      o_rsp
);
    import rcw_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [DIV_W-1:0] r_q;

    logic [DSR_W:0]   w_shift;
    logic [DSR_W:0]   w_diff;
    logic             w_fit;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        w_shift = {r_rem, r_q[DIV_W-1]};
        w_diff  = w_shift - {1'b0, r_dsr};
        w_fit   = (w_shift >= {1'b0, r_dsr});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= w_fit ? w_diff[DSR_W-1:0] : w_shift[DSR_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], w_fit};
        end else if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

`default_nettype wire

// File: sv/reading_change_warning_check.sv
// ----------------------------------------------------------------------------
// reading_change_warning_check
// Meter reading change checks with per-code warning counters.
// ----------------------------------------------------------------------------
// One item at a time. Repeat checks, the zero drop and the top limit pass
// through S_CHECK and S_FINISH to the result register. The trend checks use
// one shared 17x14 multiplier for up to four products; a trend warning then
// needs two quotients from the serial divider, the bound and then the ratio.
// The serial divider sets the worst case. The result sits in an output
// register, so the next item is taken while it waits to be collected.
// ----------------------------------------------------------------------------
`default_nettype none

module reading_change_warning_check (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    rcw_in_if.sink                      i_in,
    rcw_out_if.source                   o_out,
    input  wire logic                   i_cfg_we,
    input  wire logic [rcw_pkg::CFG_W-1:0] i_cfg_idx,
    input  wire logic [15:0]            i_cfg_data
);
    import rcw_pkg::*;

    localparam int unsigned MA_W = RD_W + 1;
    localparam int unsigned MP_W = MA_W + TRD_W;

    t_state r_state, n_state;

    // Configuration
    logic [RD_W-1:0]  r_top_limit;
    logic [TRD_W-1:0] r_trend;
    logic [BRD_W-1:0] r_border;

    // Item and working registers
    logic              r_mode;
    logic [RD_W-1:0]   r_prev;
    logic [RD_W-1:0]   r_curr;
    logic [CODE_W-1:0] r_code;
    logic [OUT_W-1:0]  r_bound;
    logic [OUT_W-1:0]  r_ratio;
    logic [DIV_W-1:0]  r_pa;
    logic [DIV_W-1:0]  r_pb;
    logic [RD_W-1:0]   r_cnt [NUM_CODES];

    // Result register
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic [OUT_W-1:0]  r_out_bound;
    logic [OUT_W-1:0]  r_out_ratio;
    logic [RD_W-1:0]   r_out_count;
    logic              r_out_req;
    logic [BRD_W-1:0]  r_out_budget;

    logic              w_accept;
    logic              w_out_free;
    logic              w_up;
    logic              w_down;
    logic [MA_W-1:0]   w_mul_a;
    logic [TRD_W-1:0]  w_mul_b;
    logic [MP_W-1:0]   w_prod;
    logic [RD_W-1:0]   w_cnt_next;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_up       = (r_pa < r_pb);
    assign w_down     = (r_trend != '0) && (r_pa <= r_pb);
    assign w_cnt_next = r_cnt[r_code] + 1'b1;

    // Shared multiplier operand selection
    always_comb begin
        w_mul_a = {1'b0, r_prev};
        w_mul_b = r_trend;
        unique case (r_state)
            S_MUL_CUR: begin
                w_mul_a = {1'b0, r_curr};
                w_mul_b = PERCENT;
            end
            S_MUL_LO: begin
                w_mul_a = {1'b0, r_curr} + 1'b1;
                w_mul_b = r_trend;
            end
            S_MUL_PRV: begin
                w_mul_a = {1'b0, r_prev};
                w_mul_b = PERCENT;
            end
            default: begin
                w_mul_a = {1'b0, r_prev};
                w_mul_b = r_trend;
            end
        endcase
        w_prod = {{TRD_W{1'b0}}, w_mul_a} * {{MA_W{1'b0}}, w_mul_b};
    end

    // Sequencer: next state and divider requests
    always_comb begin
        n_state            = r_state;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_pa;
        w_div_req.divisor  = {2'b00, PERCENT};
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (r_mode) begin
                    n_state = S_FINISH;
                end else if (r_prev != '0 && r_curr == '0) begin
                    n_state = S_FINISH;
                end else if (r_curr > r_top_limit) begin
                    n_state = S_FINISH;
                end else if (r_prev != '0 && r_curr != '0) begin
                    n_state = S_MUL_HI;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_MUL_HI:  n_state = S_MUL_CUR;
            S_MUL_CUR: n_state = S_CMP_UP;
            S_CMP_UP: begin
                if (w_up) begin
                    // bound = prev*trend/100
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = r_pa;
                    w_div_req.divisor  = {2'b00, PERCENT};
                    n_state            = S_DIV_BND;
                end else begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO:  n_state = S_MUL_PRV;
            S_MUL_PRV: n_state = S_CMP_DN;
            S_CMP_DN: begin
                if (w_down) begin
                    // bound = prev*100/trend
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = r_pb;
                    w_div_req.divisor  = {2'b00, r_trend};
                    n_state            = S_DIV_BND;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV_BND: begin
                if (w_div_rsp.done) begin
                    // ratio: curr*100/prev going up, prev*100/curr going down
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = r_pb;
                    w_div_req.divisor  = (r_code == CODE_UP) ? r_prev : r_curr;
                    n_state            = S_DIV_RAT;
                end
            end
            S_DIV_RAT: begin
                if (w_div_rsp.done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_limit <= '1;
            r_trend     <= 14'd200;
            r_border    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TOP_LIMIT: r_top_limit <= i_cfg_data;
                REG_TREND:     r_trend     <= i_cfg_data[TRD_W-1:0];
                REG_BORDER:    r_border    <= i_cfg_data[BRD_W-1:0];
                default:       ;
            endcase
        end
    end

    // Working datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_mode <= i_in.mode;
                    r_prev <= i_in.previous_reading;
                    r_curr <= i_in.current_reading;
                end
            end
            S_CHECK: begin
                r_bound <= '0;
                r_ratio <= '0;
                r_code  <= CODE_OK;
                priority if (r_mode) begin
                    if (r_prev != '0 && r_curr == r_prev) r_code <= CODE_REPEAT;
                end else if (r_prev != '0 && r_curr == '0) begin
                    r_code <= CODE_ZERO;
                end else if (r_curr > r_top_limit) begin
                    r_code  <= CODE_TOP;
                    r_bound <= {{(OUT_W-RD_W){1'b0}}, r_top_limit};
                end
            end
            S_MUL_HI:  r_pa <= w_prod[DIV_W-1:0];
            S_MUL_CUR: r_pb <= w_prod[DIV_W-1:0];
            S_CMP_UP: begin
                if (w_up) r_code <= CODE_UP;
            end
            S_MUL_LO:  r_pa <= w_prod[DIV_W-1:0];
            S_MUL_PRV: r_pb <= w_prod[DIV_W-1:0];
            S_CMP_DN: begin
                if (w_down) r_code <= CODE_DOWN;
            end
            S_DIV_BND: begin
                if (w_div_rsp.done) r_bound <= sat23(w_div_rsp.quotient);
            end
            S_DIV_RAT: begin
                if (w_div_rsp.done) r_ratio <= sat23(w_div_rsp.quotient);
            end
            default: ;
        endcase
    end

    // Warning counters, one per code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CODES; k++) r_cnt[k] <= '0;
        end else if (r_state == S_FINISH && w_out_free && r_code != CODE_OK) begin
            r_cnt[r_code] <= w_cnt_next;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINISH && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && w_out_free) begin
            r_out_code  <= r_code;
            r_out_bound <= r_bound;
            r_out_ratio <= r_ratio;
            if (r_code != CODE_OK) begin
                r_out_count  <= w_cnt_next;
                r_out_req    <= 1'b1;
                r_out_budget <= r_border;
            end else begin
                r_out_count  <= '0;
                r_out_req    <= 1'b0;
                r_out_budget <= '0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.warning_code   = r_out_code;
    assign o_out.bound_value    = r_out_bound;
    assign o_out.ratio_percent  = r_out_ratio;
    assign o_out.warning_count  = r_out_count;
    assign o_out.reread_request = r_out_req;
    assign o_out.repeat_budget  = r_out_budget;

    // Shared serial divider
    rcw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule

`default_nettype wire

// File: tb/reading_change_warning_check_tb.sv
// ----------------------------------------------------------------------------
// reading_change_warning_check_tb
// Self-checking bench for the meter reading change warning check.
// ----------------------------------------------------------------------------
// Pairs of readings go in through the input channel and are scored against a
// bench-side model of the change checks, the per-code warning counters and the
// three registers. A short directed run covers the field extremes, each
// warning code, a zero trend register and the out-of-range register index. A
// flat-out burst of repeat items then runs the block at its full rate with
// the receiver always ready. After that come several register settings with
// random items, most of them aimed at the zero, top and trend borders. Sender
// bursts, sender gaps and receiver stalls are all random.
// ----------------------------------------------------------------------------
`default_nettype none

module reading_change_warning_check_tb;

    import rcw_pkg::*;

    localparam int unsigned HALF_PERIOD  = 5;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned PHASE_ITEMS  = 180;
    localparam int unsigned NUM_PHASES   = 6;
    localparam int unsigned BURST_ITEMS  = 32;
    localparam int unsigned SETTLE_WAIT  = 8;
    localparam int unsigned TAIL_WAIT    = 80;

    // Unused register index: writes to it must change nothing
    localparam logic [CFG_W-1:0] REG_UNUSED = 2'd3;

    localparam logic MODE_CHANGE = 1'b0;
    localparam logic MODE_REPEAT = 1'b1;

    // One result item
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [OUT_W-1:0]  bound;
        logic [OUT_W-1:0]  ratio;
        logic [RD_W-1:0]   count;
        logic              reread;
        logic [BRD_W-1:0]  budget;
    } t_warning_result;

    // ------------------------------------------------------------------------
    // Warning ledger: register copy, counters and the queue of due warnings
    // ------------------------------------------------------------------------
    class t_warning_ledger;
        logic [RD_W-1:0]  top_limit;
        logic [TRD_W-1:0] trend_percent;
        logic [BRD_W-1:0] border_repeats;
        logic [RD_W-1:0]  code_counts [NUM_CODES];
        t_warning_result  due_warnings [$];
        int unsigned      failures;

        function new();
            top_limit      = 16'hFFFF;
            trend_percent  = 14'd200;
            border_repeats = '0;
            foreach (code_counts[k]) code_counts[k] = '0;
            failures = 0;
        endfunction

        function void write_register(logic [CFG_W-1:0] idx, logic [15:0] data);
            case (idx)
                REG_TOP_LIMIT: top_limit      = data[RD_W-1:0];
                REG_TREND:     trend_percent  = data[TRD_W-1:0];
                REG_BORDER:    border_repeats = data[BRD_W-1:0];
                default: ;
            endcase
        endfunction

        // Clip to the 23-bit result fields
        function logic [OUT_W-1:0] clip(longint unsigned v);
            return (v > longint'(SAT_MAX)) ? SAT_MAX : OUT_W'(v);
        endfunction

        // Work out the warning for one accepted pair of readings
        function void note_reading(logic mode, logic [RD_W-1:0] prev,
                                   logic [RD_W-1:0] curr);
            longint unsigned p, c, t, rise_max, fall_min;
            t_warning_result w;
            p = prev;
            c = curr;
            t = trend_percent;
            w = '0;
            w.code = CODE_OK;
            if (mode == MODE_CHANGE) begin
                if (p != 0 && c == 0) begin
                    w.code = CODE_ZERO;
                end else if (curr > top_limit) begin
                    w.code  = CODE_TOP;
                    w.bound = OUT_W'(top_limit);
                end else if (p != 0 && c != 0) begin
                    rise_max = p * t / PERCENT;
                    if (c > rise_max) begin
                        w.code  = CODE_UP;
                        w.bound = clip(rise_max);
                        w.ratio = clip(c * PERCENT / p);
                    end else if (t != 0) begin
                        fall_min = p * PERCENT / t;
                        if (c < fall_min) begin
                            w.code  = CODE_DOWN;
                            w.bound = clip(fall_min);
                            w.ratio = clip(p * PERCENT / c);
                        end
                    end
                end
            end else if (p != 0 && c == p) begin
                w.code = CODE_REPEAT;
            end
            // Each code counts on its own wrapping counter
            if (w.code != CODE_OK) begin
                code_counts[w.code] = code_counts[w.code] + 16'd1;
                w.count  = code_counts[w.code];
                w.reread = 1'b1;
                w.budget = border_repeats;
            end
            due_warnings.push_back(w);
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            failures++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field, want, got);
        endfunction

        // Compare one result item against the oldest due warning
        function void check_warning(t_warning_result got);
            t_warning_result want;
            if (due_warnings.size() == 0) begin
                report("unrequested item, warning_code", CODE_OK, got.code);
                return;
            end
            want = due_warnings.pop_front();
            if (got.code   != want.code)   report("warning_code",   want.code,   got.code);
            if (got.bound  != want.bound)  report("bound_value",    want.bound,  got.bound);
            if (got.ratio  != want.ratio)  report("ratio_percent",  want.ratio,  got.ratio);
            if (got.count  != want.count)  report("warning_count",  want.count,  got.count);
            if (got.reread != want.reread) report("reread_request", want.reread, got.reread);
            if (got.budget != want.budget) report("repeat_budget",  want.budget, got.budget);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block
    // ------------------------------------------------------------------------
    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_idx = '0;
    logic [15:0]      i_cfg_data = '0;

    logic             full_rate = 1'b0;
    logic [15:0]      stall_pattern = 16'hFFFF;
    logic [5:0]       pattern_age = '0;

    t_warning_ledger  ledger;

    rcw_in_if  in_ch ();
    rcw_out_if out_ch ();

    reading_change_warning_check DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Receiver: stall pattern picked anew each time the 6-bit age counter wraps, all ready at full rate
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (full_rate) begin
            out_ch.ready = 1'b1;
        end else begin
            if (pattern_age == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    stall_pattern = 16'hFFFF;
                end else begin
                    stall_pattern = 16'($urandom) | 16'h0001;
                end
            end
            pattern_age   = pattern_age + 6'd1;
            out_ch.ready  = stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // Score every result item taken
    always @(posedge i_clk) begin
        t_warning_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.code   = out_ch.warning_code;
            got.bound  = out_ch.bound_value;
            got.ratio  = out_ch.ratio_percent;
            got.count  = out_ch.warning_count;
            got.reread = out_ch.reread_request;
            got.budget = out_ch.repeat_budget;
            ledger.check_warning(got);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_item(logic mode, logic [RD_W-1:0] prev, logic [RD_W-1:0] curr);
        @(negedge i_clk);
        in_ch.valid            = 1'b1;
        in_ch.mode             = mode;
        in_ch.previous_reading = prev;
        in_ch.current_reading  = curr;
        do @(posedge i_clk); while (!in_ch.ready);
        ledger.note_reading(mode, prev, curr);
    endtask

    task automatic pause_sender(int unsigned cycles);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Only called once the block has gone idle
    task automatic write_register(logic [CFG_W-1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        ledger.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_for_idle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (ledger.due_warnings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Reading near a border, stays inside 1..65535
    function automatic logic [RD_W-1:0] near_reading(longint unsigned border);
        longint s;
        if (border > 65535) return RD_W'($urandom_range(1, 65535));
        s = longint'(border) + longint'($urandom_range(0, 4)) - 2;
        if (s < 1) s = 1;
        if (s > 65535) s = 65535;
        return RD_W'(s);
    endfunction

    // Mostly small previous readings, never zero
    function automatic logic [RD_W-1:0] pick_previous();
        logic [RD_W-1:0] r;
        r = RD_W'($urandom_range(1, 65535) >> $urandom_range(0, 15));
        return (r == 0) ? 16'd1 : r;
    endfunction

    // One random item, most of them aimed at a border of some check
    task automatic send_random_item();
        int unsigned     pick;
        logic            mode;
        logic [RD_W-1:0] prev, curr;
        longint unsigned p, t;
        pick = $urandom_range(0, 99);
        mode = MODE_CHANGE;
        prev = pick_previous();
        curr = RD_W'($urandom);
        p    = prev;
        t    = ledger.trend_percent;
        if (pick < 10) begin
            curr = '0;
        end else if (pick < 20) begin
            if (ledger.top_limit != 16'hFFFF) begin
                curr = RD_W'($urandom_range(int'(ledger.top_limit) + 1, 65535));
            end
        end else if (pick < 30) begin
            mode = MODE_REPEAT;
            if ($urandom_range(0, 7) == 0) prev = '0;
            curr = prev;
        end else if (pick < 38) begin
            mode = MODE_REPEAT;
            prev = RD_W'($urandom);
        end else if (pick < 62) begin
            curr = near_reading(p * t / PERCENT);
        end else if (pick < 82) begin
            if (t != 0) curr = near_reading(p * PERCENT / t);
        end else begin
            mode = 1'($urandom);
            prev = RD_W'($urandom);
        end
        send_item(mode, prev, curr);
    endtask

    // Register setting for one random phase
    task automatic set_phase_registers(int unsigned phase);
        case (phase)
            0: begin
                write_register(REG_TOP_LIMIT, 16'hFFFF);
                write_register(REG_TREND, 16'd10000);
                write_register(REG_BORDER, 16'($urandom));
            end
            1: begin
                write_register(REG_TOP_LIMIT, 16'd0);
                write_register(REG_TREND, 16'd100);
                write_register(REG_BORDER, 16'd255);
            end
            2: begin
                write_register(REG_TOP_LIMIT, 16'($urandom));
                write_register(REG_TREND, 16'hFFFF);
                write_register(REG_BORDER, 16'd0);
            end
            3: begin
                write_register(REG_TOP_LIMIT, 16'($urandom_range(32768, 65535)));
                write_register(REG_TREND, 16'd0);
                write_register(REG_BORDER, 16'($urandom));
            end
            default: begin
                write_register(REG_TOP_LIMIT, 16'($urandom));
                write_register(REG_TREND, {2'($urandom), 14'($urandom_range(100, 10000))});
                write_register(REG_BORDER, 16'($urandom));
            end
        endcase
        write_register(REG_UNUSED, 16'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned     sent;
        int unsigned     burst;
        int unsigned     gap;
        logic [RD_W-1:0] v;

        ledger = new();
        in_ch.valid            = 1'b0;
        in_ch.mode             = MODE_CHANGE;
        in_ch.previous_reading = '0;
        in_ch.current_reading  = '0;
        out_ch.ready           = 1'b1;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: field extremes and every code but the top limit
        send_item(MODE_CHANGE, 16'd0, 16'd0);
        send_item(MODE_CHANGE, 16'd5, 16'd0);
        send_item(MODE_CHANGE, 16'd0, 16'hFFFF);
        send_item(MODE_CHANGE, 16'd100, 16'd201);
        send_item(MODE_CHANGE, 16'd100, 16'd200);
        send_item(MODE_CHANGE, 16'd100, 16'd50);
        send_item(MODE_CHANGE, 16'd100, 16'd49);
        send_item(MODE_CHANGE, 16'hFFFF, 16'd1);
        send_item(MODE_CHANGE, 16'd1, 16'hFFFF);
        send_item(MODE_REPEAT, 16'hFFFF, 16'hFFFF);
        send_item(MODE_REPEAT, 16'd0, 16'd0);
        send_item(MODE_REPEAT, 16'd1, 16'd2);
        send_item(MODE_REPEAT, 16'hAAAA, 16'h5555);
        wait_for_idle();

        // Zero trend register: any rise after a nonzero reading warns
        write_register(REG_TOP_LIMIT, 16'd1000);
        write_register(REG_TREND, 16'd0);
        write_register(REG_BORDER, 16'd255);
        send_item(MODE_CHANGE, 16'd500, 16'd1001);
        send_item(MODE_CHANGE, 16'd500, 16'd1000);
        send_item(MODE_CHANGE, 16'd0, 16'd1);
        send_item(MODE_CHANGE, 16'hFFFF, 16'd0);
        wait_for_idle();

        // Zero top limit, widest trend, upper data bits dropped, unused index
        write_register(REG_TOP_LIMIT, 16'd0);
        write_register(REG_TREND, 16'hFFFF);
        write_register(REG_BORDER, 16'hFF5A);
        write_register(REG_UNUSED, 16'h1234);
        send_item(MODE_CHANGE, 16'd0, 16'd0);
        send_item(MODE_CHANGE, 16'd0, 16'd1);
        wait_for_idle();
        write_register(REG_TOP_LIMIT, 16'hFFFF);
        send_item(MODE_CHANGE, 16'hFFFF, 16'd1);
        send_item(MODE_CHANGE, 16'hFFFF, 16'hFFFF);
        wait_for_idle();

        // Trend of one percent: rise bound far below the previous reading
        write_register(REG_TREND, 16'd1);
        send_item(MODE_CHANGE, 16'hFFFF, 16'd656);
        send_item(MODE_CHANGE, 16'd100, 16'd100);
        wait_for_idle();

        // Flat-out repeat burst with the receiver always ready
        full_rate = 1'b1;
        repeat (BURST_ITEMS) begin
            v = RD_W'($urandom_range(1, 65535));
            send_item(MODE_REPEAT, v, v);
        end
        wait_for_idle();
        full_rate = 1'b0;

        // Random phases, one register setting each
        for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
            set_phase_registers(phase);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 12);
                repeat (burst) begin
                    send_random_item();
                    sent++;
                end
                // Phase two runs without sender gaps
                if (phase != 2) begin
                    gap = $urandom_range(0, 15);
                    if (gap != 0) pause_sender(gap);
                end
            end
            wait_for_idle();
        end

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (ledger.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
